// File: design/jads_pkg.sv
// ----------------------------------------------------------------------------
// jads_pkg: shared types and constants of the joystick axis deadzone scaler
// Register indexes, result kinds, fixed output widths and scale constants.
// ----------------------------------------------------------------------------
package jads_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned POS_BITS        = 17;
  localparam int unsigned OUT_TDATA_W     = ((POS_BITS + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W       = 3;

  localparam int STICK_FULL = 32767;
  localparam int TRIG_FULL  = 65535;

  localparam int CENTER_RST = 1800;
  localparam int LOW_RST    = 400;
  localparam int HIGH_RST   = 3200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_MODE       = 3'd0,
    CFG_CENTER_LEVEL    = 3'd1,
    CFG_LOW_LIMIT       = 3'd2,
    CFG_HIGH_LIMIT      = 3'd3,
    CFG_CENTER_DEADZONE = 3'd4,
    CFG_EDGE_DEADZONE   = 3'd5,
    CFG_INVERT          = 3'd6
  } cfg_idx_e;

  // How the final position is formed
  typedef enum logic [1:0] {
    KIND_DIV  = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_FULL = 2'd2
  } kind_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  neg;
    logic  trig;
  } ctl_t;

endpackage

// File: design/jads_div_cell.sv
// ----------------------------------------------------------------------------
// jads_div_cell: one restoring division step
// Takes one numerator bit, produces one quotient bit, registers the partial
// remainder and hands everything to the next cell.
// ----------------------------------------------------------------------------
module jads_div_cell #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned NUM_BITS    = 29
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  jads_pkg::ctl_t         ctl_i,
  input  logic [SAMPLE_BITS-1:0] rem_i,
  input  logic [NUM_BITS-1:0]    nq_i,
  input  logic [SAMPLE_BITS-1:0] div_i,
  output jads_pkg::ctl_t         ctl_o,
  output logic [SAMPLE_BITS-1:0] rem_o,
  output logic [NUM_BITS-1:0]    nq_o,
  output logic [SAMPLE_BITS-1:0] div_o
);
  import jads_pkg::*;

  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   diff;
  logic                   ge;
  ctl_t                   ctl_q;
  logic [SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [NUM_BITS-1:0]    nq_q, nq_d;
  logic [SAMPLE_BITS-1:0] div_q;

  // remainder stays below the divisor, so it fits SAMPLE_BITS before the shift
  assign trial = {rem_i, nq_i[NUM_BITS-1]};
  assign diff  = trial - {1'b0, div_i};
  assign ge    = (trial >= {1'b0, div_i});
  assign rem_d = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
  // numerator bits leave at the top, quotient bits enter at the bottom
  assign nq_d  = {nq_i[NUM_BITS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      div_q <= div_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign nq_o  = nq_q;
  assign div_o = div_q;

endmodule

// File: design/jads_front.sv
// ----------------------------------------------------------------------------
// jads_front: band and span evaluation, then constant scaling
// Stage A picks the case and forms magnitude and span; stage B multiplies
// the magnitude by the full-scale constant with a shift and subtract.
// ----------------------------------------------------------------------------
module jads_front #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned NUM_BITS    = 29
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   axis_mode_i,
  input  logic [SAMPLE_BITS-1:0] center_level_i,
  input  logic [SAMPLE_BITS-1:0] low_limit_i,
  input  logic [SAMPLE_BITS-1:0] high_limit_i,
  input  logic [SAMPLE_BITS-1:0] center_deadzone_i,
  input  logic [SAMPLE_BITS-1:0] edge_deadzone_i,
  input  logic                   invert_i,
  output jads_pkg::ctl_t         ctl_o,
  output logic [NUM_BITS-1:0]    num_o,
  output logic [SAMPLE_BITS-1:0] div_o
);
  import jads_pkg::*;

  localparam int unsigned EW = SAMPLE_BITS + 3;

  logic signed [EW-1:0] s_x, c_x, cd_x, ed_x, lo_x, hi_x;
  logic signed [EW-1:0] lo_edge, hi_edge, lo_lim, hi_lim;
  logic signed [EW-1:0] sspan_lo, sspan_hi, tspan;
  logic signed [EW-1:0] n_lo, n_hi, n_tr;
  logic signed [EW-1:0] mag_x, div_x;
  ctl_t                 a_ctl_d, a_ctl_q, b_ctl_q;
  logic [SAMPLE_BITS:0]   a_mag_q;
  logic [SAMPLE_BITS-1:0] a_div_q, b_div_q;
  logic [NUM_BITS-1:0]    shifted, b_num_d, b_num_q;

  assign s_x  = $signed({3'b000, sample_i});
  assign c_x  = $signed({3'b000, center_level_i});
  assign cd_x = $signed({3'b000, center_deadzone_i});
  assign ed_x = $signed({3'b000, edge_deadzone_i});
  assign lo_x = $signed({3'b000, low_limit_i});
  assign hi_x = $signed({3'b000, high_limit_i});

  assign lo_edge  = c_x - cd_x;
  assign hi_edge  = c_x + cd_x;
  assign lo_lim   = lo_x + ed_x;
  assign hi_lim   = hi_x - ed_x;
  assign sspan_lo = lo_edge - lo_lim;
  assign sspan_hi = hi_lim - hi_edge;
  assign tspan    = hi_lim - lo_lim;
  assign n_lo     = lo_edge - s_x;
  assign n_hi     = s_x - hi_edge;
  assign n_tr     = hi_lim - s_x;

  always_comb begin
    a_ctl_d       = '0;
    a_ctl_d.valid = valid_i;
    a_ctl_d.trig  = axis_mode_i;
    a_ctl_d.kind  = KIND_ZERO;
    mag_x         = n_tr;
    div_x         = tspan;
    if (axis_mode_i) begin
      if (tspan <= 0) begin
        a_ctl_d.kind = KIND_ZERO;
      end else if (s_x <= lo_lim) begin
        a_ctl_d.kind = KIND_FULL;
      end else if (s_x >= hi_lim) begin
        a_ctl_d.kind = KIND_ZERO;
      end else begin
        a_ctl_d.kind = KIND_DIV;
      end
    end else if ((s_x > lo_edge) && (s_x < hi_edge)) begin
      a_ctl_d.kind = KIND_ZERO;
    end else if (s_x < c_x) begin
      // below center the distance is negative: carry magnitude and sign
      mag_x        = n_lo;
      div_x        = sspan_lo;
      a_ctl_d.neg  = ~invert_i;
      a_ctl_d.kind = (sspan_lo <= 0) ? KIND_ZERO : KIND_DIV;
    end else begin
      mag_x        = n_hi;
      div_x        = sspan_hi;
      a_ctl_d.neg  = invert_i;
      a_ctl_d.kind = (sspan_hi <= 0) ? KIND_ZERO : KIND_DIV;
    end
  end

  // magnitude times 65535 or 32767
  assign shifted = a_ctl_q.trig ? {a_mag_q, 16'h0000} : {1'b0, a_mag_q, 15'h0000};
  assign b_num_d = shifted - {16'h0000, a_mag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
    end else if (en_i) begin
      a_ctl_q <= a_ctl_d;
      b_ctl_q <= a_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q <= mag_x[SAMPLE_BITS:0];
      a_div_q <= div_x[SAMPLE_BITS-1:0];
      b_num_q <= b_num_d;
      b_div_q <= a_div_q;
    end
  end

  assign ctl_o = b_ctl_q;
  assign num_o = b_num_q;
  assign div_o = b_div_q;

endmodule

// File: design/joystick_axis_deadzone_scaler.sv
// ----------------------------------------------------------------------------
// joystick_axis_deadzone_scaler: calibrated position from one axis sample
// Deadzone and span evaluation, a chain of division cells and an output
// register with a skid entry.
// ----------------------------------------------------------------------------
// Path from input transfer to output valid: two front stages, one division
//   cell per numerator bit, and the output register.
// Throughput: one sample per cycle; the division chain retires one bit per cell.
// Backpressure freezes the whole chain only once the skid entry is full.
// Reset: asynchronous, active low; clears valid state and loads register defaults.
module joystick_axis_deadzone_scaler
  import jads_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // fields: raw_sample[SAMPLE_BITS-1:0], zero padded
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // fields: position[16:0] signed, zero padded
  output logic [jads_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [jads_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]                 cfg_data_i
);
  import jads_pkg::*;

  localparam int unsigned NUM_BITS = SAMPLE_BITS + 17;

  logic                   axis_mode_q, invert_q;
  logic [SAMPLE_BITS-1:0] center_level_q, low_limit_q, high_limit_q;
  logic [SAMPLE_BITS-1:0] center_deadzone_q, edge_deadzone_q;

  logic                   en;
  ctl_t                   ctl_c [NUM_BITS+1];
  logic [SAMPLE_BITS-1:0] rem_c [NUM_BITS+1];
  logic [NUM_BITS-1:0]    nq_c  [NUM_BITS+1];
  logic [SAMPLE_BITS-1:0] div_c [NUM_BITS+1];

  ctl_t                   res_ctl;
  logic [NUM_BITS-1:0]    quot;
  logic [14:0]            stick_mag;
  logic [POS_BITS-1:0]    res_pos;
  logic                   out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic [POS_BITS-1:0]    out_q, out_d, skid_q, skid_d;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_mode_q       <= 1'b0;
      center_level_q    <= SAMPLE_BITS'(CENTER_RST);
      low_limit_q       <= SAMPLE_BITS'(LOW_RST);
      high_limit_q      <= SAMPLE_BITS'(HIGH_RST);
      center_deadzone_q <= '0;
      edge_deadzone_q   <= '0;
      invert_q          <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_AXIS_MODE:       axis_mode_q       <= cfg_data_i[0];
        CFG_CENTER_LEVEL:    center_level_q    <= cfg_data_i;
        CFG_LOW_LIMIT:       low_limit_q       <= cfg_data_i;
        CFG_HIGH_LIMIT:      high_limit_q      <= cfg_data_i;
        CFG_CENTER_DEADZONE: center_deadzone_q <= cfg_data_i;
        CFG_EDGE_DEADZONE:   edge_deadzone_q   <= cfg_data_i;
        CFG_INVERT:          invert_q          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // the chain advances as long as the skid entry is free
  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;

  jads_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_BITS    (NUM_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (s_axis_tvalid),
    .sample_i          (s_axis_tdata[SAMPLE_BITS-1:0]),
    .axis_mode_i       (axis_mode_q),
    .center_level_i    (center_level_q),
    .low_limit_i       (low_limit_q),
    .high_limit_i      (high_limit_q),
    .center_deadzone_i (center_deadzone_q),
    .edge_deadzone_i   (edge_deadzone_q),
    .invert_i          (invert_q),
    .ctl_o             (ctl_c[0]),
    .num_o             (nq_c[0]),
    .div_o             (div_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar g = 0; g < NUM_BITS; g++) begin : g_cell
    jads_div_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .NUM_BITS    (NUM_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_c[g]),
      .rem_i  (rem_c[g]),
      .nq_i   (nq_c[g]),
      .div_i  (div_c[g]),
      .ctl_o  (ctl_c[g+1]),
      .rem_o  (rem_c[g+1]),
      .nq_o   (nq_c[g+1]),
      .div_o  (div_c[g+1])
    );
  end

  // final mapping: clamp, sign, select by kind
  assign res_ctl   = ctl_c[NUM_BITS];
  assign quot      = nq_c[NUM_BITS];
  assign stick_mag = (quot > NUM_BITS'(STICK_FULL)) ? 15'h7fff : quot[14:0];

  always_comb begin
    unique case (res_ctl.kind)
      KIND_ZERO: res_pos = '0;
      KIND_FULL: res_pos = POS_BITS'(TRIG_FULL);
      KIND_DIV: begin
        if (res_ctl.trig) begin
          res_pos = {1'b0, quot[15:0]};
        end else if (res_ctl.neg) begin
          res_pos = -{2'b00, stick_mag};
        end else begin
          res_pos = {2'b00, stick_mag};
        end
      end
      default: res_pos = '0;
    endcase
  end

  // output register with one skid entry
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!out_vld_q || m_axis_tready) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else if (res_ctl.valid) begin
        out_d     = res_pos;
        out_vld_d = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (res_ctl.valid && en) begin
      skid_d     = res_pos;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-POS_BITS){1'b0}}, out_q};

endmodule

// File: bench/tb_joystick_axis_deadzone_scaler.sv
// ----------------------------------------------------------------------------
// tb_joystick_axis_deadzone_scaler: self-checking bench of the axis scaler
// Streams raw samples under a series of calibration settings, predicts each
// position in a scoreboard and compares every output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_joystick_axis_deadzone_scaler;
  import jads_pkg::*;

  localparam int unsigned SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int unsigned IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned NUM_REGS    = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int unsigned IDLE_PCT    = 26;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned SETTLE_CYCLES = SAMPLE_W + 28;
  localparam int unsigned STALL_LIMIT = 2000;

  class position_scoreboard;
    logic [SAMPLE_W-1:0]    regs [NUM_REGS];
    logic signed [POS_BITS-1:0] expected_q [$];
    int unsigned            errors;

    function new();
      regs[CFG_AXIS_MODE]       = '0;
      regs[CFG_CENTER_LEVEL]    = SAMPLE_W'(CENTER_RST);
      regs[CFG_LOW_LIMIT]       = SAMPLE_W'(LOW_RST);
      regs[CFG_HIGH_LIMIT]      = SAMPLE_W'(HIGH_RST);
      regs[CFG_CENTER_DEADZONE] = '0;
      regs[CFG_EDGE_DEADZONE]   = '0;
      regs[CFG_INVERT]          = '0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
      case (idx)
        CFG_AXIS_MODE, CFG_INVERT: regs[idx] = {{(SAMPLE_W-1){1'b0}}, val[0]};
        CFG_CENTER_LEVEL, CFG_LOW_LIMIT, CFG_HIGH_LIMIT,
        CFG_CENTER_DEADZONE, CFG_EDGE_DEADZONE: regs[idx] = val;
        default: ;
      endcase
    endfunction

    function logic signed [POS_BITS-1:0] map_position(logic [SAMPLE_W-1:0] raw);
      longint s, c, cd, ed, low, high;
      longint lo_edge, hi_edge, span, num, v;
      s    = raw;
      c    = regs[CFG_CENTER_LEVEL];
      cd   = regs[CFG_CENTER_DEADZONE];
      ed   = regs[CFG_EDGE_DEADZONE];
      low  = regs[CFG_LOW_LIMIT];
      high = regs[CFG_HIGH_LIMIT];
      v    = 0;
      if (regs[CFG_AXIS_MODE][0]) begin
        // trigger: full scale at the low end, reversed linear in between
        lo_edge = low + ed;
        hi_edge = high - ed;
        span    = hi_edge - lo_edge;
        if (span <= 0) v = 0;
        else if (s <= lo_edge) v = TRIG_FULL;
        else if (s >= hi_edge) v = 0;
        else v = ((hi_edge - s) * TRIG_FULL) / span;
      end else begin
        lo_edge = c - cd;
        hi_edge = c + cd;
        if (!(s > lo_edge && s < hi_edge)) begin
          if (s < c) begin
            span = lo_edge - (low + ed);
            num  = s - lo_edge;
          end else begin
            span = (high - ed) - hi_edge;
            num  = s - hi_edge;
          end
          if (span > 0) begin
            // signed division truncates toward zero
            v = (num * STICK_FULL) / span;
            if (regs[CFG_INVERT][0]) v = -v;
            if (v > STICK_FULL) v = STICK_FULL;
            if (v < -STICK_FULL) v = -STICK_FULL;
          end
        end
      end
      return v[POS_BITS-1:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw);
      expected_q.push_back(map_position(raw));
    endfunction

    function void check_position(logic signed [POS_BITS-1:0] got);
      logic signed [POS_BITS-1:0] want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected position transfer, expected none, actual %0d", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (want !== got) begin
          errors++;
          $display("%0t: position mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [SAMPLE_W-1:0]    cfg_data_i = '0;

  position_scoreboard sb = new();
  logic [SAMPLE_W-1:0] cfg_next [NUM_REGS];
  logic                calm = 1'b0;
  int unsigned         idle_cycles = 0;

  joystick_axis_deadzone_scaler #(
    .SAMPLE_BITS(SAMPLE_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random backpressure unless in the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_position(m_axis_tdata[POS_BITS-1:0]);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(raw);
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(raw);
  endtask

  // hold off the sender until every expected position has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, val);
  endtask

  task automatic commit_config();
    drain();
    for (int i = 0; i < NUM_REGS; i++) begin
      write_reg(CFG_IDX_W'(i), cfg_next[i]);
    end
    // the unused index must leave every register alone
    write_reg(CFG_UNUSED_IDX, SAMPLE_W'($urandom_range(SAMPLE_MAX)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input int mode, input int center, input int low, input int high,
                            input int cdz, input int edz, input int inv);
    cfg_next[CFG_AXIS_MODE]       = SAMPLE_W'(mode);
    cfg_next[CFG_CENTER_LEVEL]    = SAMPLE_W'(center);
    cfg_next[CFG_LOW_LIMIT]       = SAMPLE_W'(low);
    cfg_next[CFG_HIGH_LIMIT]      = SAMPLE_W'(high);
    cfg_next[CFG_CENTER_DEADZONE] = SAMPLE_W'(cdz);
    cfg_next[CFG_EDGE_DEADZONE]   = SAMPLE_W'(edz);
    cfg_next[CFG_INVERT]          = SAMPLE_W'(inv);
    commit_config();
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned style;
    int lo, hi, ctr, anchor, s;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: rails, center and its neighbors, low limit
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(CENTER_RST));
    send_sample(SAMPLE_W'(CENTER_RST - 1));
    send_sample(SAMPLE_W'(CENTER_RST + 1));
    send_sample(SAMPLE_W'(LOW_RST));

    // deadzones with invert: band edges, shrunk limit, beyond the limits
    set_config(0, 2048, 400, 3200, 100, 50, 1);
    send_sample(SAMPLE_W'(1948));
    send_sample(SAMPLE_W'(1949));
    send_sample(SAMPLE_W'(2148));
    send_sample(SAMPLE_W'(450));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(SAMPLE_MAX));

    // band reaching below zero, and an empty span on the high side
    set_config(0, 100, 400, 250, 200, 0, 0);
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(300));
    send_sample(SAMPLE_W'(SAMPLE_MAX));

    // trigger around both shrunk limits, invert set but ignored
    set_config(1, 1800, 400, 3200, 0, 100, 1);
    send_sample(SAMPLE_W'(500));
    send_sample(SAMPLE_W'(499));
    send_sample(SAMPLE_W'(501));
    send_sample(SAMPLE_W'(3100));
    send_sample(SAMPLE_W'(3099));

    // empty trigger span
    set_config(1, 1800, 2000, 2100, 0, 50, 0);
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(2050));

    // register extremes
    set_config(1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    set_config(0, 0, 0, 0, 0, 0, 0);
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(SAMPLE_MAX));

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      style = $urandom_range(9);
      if (style <= 6) begin
        lo  = $urandom_range(1500);
        hi  = $urandom_range(SAMPLE_MAX, 2500);
        ctr = $urandom_range(hi, lo);
        cfg_next[CFG_LOW_LIMIT]       = SAMPLE_W'(lo);
        cfg_next[CFG_HIGH_LIMIT]      = SAMPLE_W'(hi);
        cfg_next[CFG_CENTER_LEVEL]    = SAMPLE_W'(ctr);
        cfg_next[CFG_CENTER_DEADZONE] = SAMPLE_W'($urandom_range(300));
        cfg_next[CFG_EDGE_DEADZONE]   = SAMPLE_W'($urandom_range(300));
      end else begin
        for (int i = CFG_CENTER_LEVEL; i <= CFG_EDGE_DEADZONE; i++) begin
          if (style == 9) cfg_next[i] = ($urandom_range(1) != 0) ? SAMPLE_W'(SAMPLE_MAX) : '0;
          else cfg_next[i] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
        end
      end
      // one-bit registers get random upper bits, which must be dropped
      cfg_next[CFG_AXIS_MODE] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
      cfg_next[CFG_INVERT]    = SAMPLE_W'($urandom_range(SAMPLE_MAX));
      commit_config();

      calm = (phase == 3);
      phase_len = $urandom_range(120, 80);
      for (int n = 0; n < phase_len; n++) begin
        if ($urandom_range(99) < 80) begin
          s = $urandom_range(SAMPLE_MAX);
        end else begin
          // land near a breakpoint of the current calibration
          case ($urandom_range(3))
            0: anchor = sb.regs[CFG_LOW_LIMIT] + sb.regs[CFG_EDGE_DEADZONE];
            1: anchor = sb.regs[CFG_HIGH_LIMIT] - sb.regs[CFG_EDGE_DEADZONE];
            2: anchor = sb.regs[CFG_CENTER_LEVEL] - sb.regs[CFG_CENTER_DEADZONE];
            default: anchor = sb.regs[CFG_CENTER_LEVEL] + sb.regs[CFG_CENTER_DEADZONE];
          endcase
          s = anchor + $urandom_range(6) - 3;
          if (s < 0) s = 0;
          if (s > SAMPLE_MAX) s = SAMPLE_MAX;
        end
        send_sample(SAMPLE_W'(s));
      end
      sent += phase_len;
      phase++;
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected positions never arrived", $time, sb.expected_q.size());
    end
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/jads_pkg.sv
design/jads_div_cell.sv
design/jads_front.sv
design/joystick_axis_deadzone_scaler.sv
bench/tb_joystick_axis_deadzone_scaler.sv
